// ===== src/nmcm_pkg.sv =====
// Shared types and constants for the nested mesh coordinate mapper.
// Used by the divider, datapath, controller and top level.
package nmcm_pkg;

  localparam int LEVELS          = 4;
  localparam int GRIDS_PER_LEVEL = 16;
  localparam int LVL_W           = 2;
  localparam int IDX_W           = 4;
  localparam int ADDR_W          = LVL_W + IDX_W;
  localparam int ENTRIES         = LEVELS * GRIDS_PER_LEVEL;
  localparam int COORD_W         = 15;
  localparam int POS_W           = 18;
  localparam int RATIO_W         = 5;
  localparam int CNT_W           = 5;
  localparam int NL_W            = 3;
  localparam int STEP_W          = 5;

  typedef enum logic [1:0] {
    CMD_LOAD_ENTRY = 2'd0,
    CMD_LOAD_LEVEL = 2'd1,
    CMD_MAP        = 2'd2,
    CMD_BOUNDARY   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [IDX_W-1:0]   parent;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_MAP_INIT,
    OP_EDGE_INIT,
    OP_ADD,
    OP_DIV_START,
    OP_DIV_TAKE,
    OP_NEXT_LEVEL,
    OP_EDGE_START,
    OP_NEXT_EDGE,
    OP_HIT,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_USE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SCAN,
    ST_CHECK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic is_boundary;
    logic first;
    logic lvl_zero;
    logic div_done;
    logic level_ok;
    logic index_ok;
    logic match;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/nmcm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nmcm_pkg for widths.
module nmcm_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [nmcm_pkg::POS_W-1:0]     dividend,
  input  logic [nmcm_pkg::RATIO_W-1:0]   divisor,
  output logic                           done,
  output logic [nmcm_pkg::POS_W-1:0]     quotient
);

  logic [nmcm_pkg::RATIO_W-1:0] rem;
  logic [nmcm_pkg::RATIO_W-1:0] dvs;
  logic [nmcm_pkg::POS_W-1:0]   q;
  logic [nmcm_pkg::STEP_W-1:0]  cnt;
  logic                         busy;
  logic [nmcm_pkg::RATIO_W:0]   trial;
  logic                         fits;

  assign trial    = {rem, q[nmcm_pkg::POS_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= nmcm_pkg::STEP_W'(nmcm_pkg::POS_W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      q   <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= nmcm_pkg::RATIO_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[nmcm_pkg::RATIO_W-1:0];
      end
      q <= {q[nmcm_pkg::POS_W-2:0], fits};
    end
  end

endmodule

// ===== src/nmcm_datapath.sv =====
// Datapath: submesh table, level registers, position register, divider and
// result register. Driven by nmcm_ctrl ops; depends on nmcm_pkg and nmcm_div.
module nmcm_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  nmcm_pkg::dp_op_t                op,
  output nmcm_pkg::dp_status_t            status,
  input  logic [95:0]                     s_axis_tdata,
  input  logic [1:0]                      s_axis_tuser,
  input  logic                            cfg_we,
  input  logic [nmcm_pkg::NL_W-1:0]       cfg_wdata,
  input  logic                            m_axis_tready,
  output logic                            m_axis_tvalid,
  output logic [23:0]                     m_axis_tdata,
  output logic                            m_axis_tuser
);

  // input fields
  logic                            in_axis;
  logic [nmcm_pkg::LVL_W-1:0]      in_level;
  logic [nmcm_pkg::IDX_W-1:0]      in_grid;
  logic [nmcm_pkg::COORD_W-1:0]    in_coord;
  nmcm_pkg::entry_t                in_entry;
  logic [nmcm_pkg::RATIO_W-1:0]    in_ratio;
  logic [nmcm_pkg::CNT_W-1:0]      in_count;
  nmcm_pkg::cmd_t                  in_cmd;

  assign in_axis         = s_axis_tdata[0];
  assign in_level        = s_axis_tdata[2:1];
  assign in_grid         = s_axis_tdata[6:3];
  assign in_coord        = s_axis_tdata[21:7];
  assign in_entry.origin_x = s_axis_tdata[36:22];
  assign in_entry.origin_y = s_axis_tdata[51:37];
  assign in_entry.width  = s_axis_tdata[66:52];
  assign in_entry.height = s_axis_tdata[81:67];
  assign in_entry.parent = s_axis_tdata[85:82];
  assign in_ratio        = s_axis_tdata[90:86];
  assign in_count        = s_axis_tdata[95:91];
  assign in_cmd          = nmcm_pkg::cmd_t'(s_axis_tuser);

  nmcm_pkg::entry_t               mem [nmcm_pkg::ENTRIES];
  nmcm_pkg::entry_t               rd_entry;
  logic [nmcm_pkg::RATIO_W-1:0]   ratio_store [nmcm_pkg::LEVELS];
  logic [nmcm_pkg::CNT_W-1:0]     count_store [nmcm_pkg::LEVELS];
  logic [nmcm_pkg::NL_W-1:0]      num_levels;

  logic                           q_axis;
  logic                           q_bnd;
  logic [nmcm_pkg::COORD_W-1:0]   q_coord;
  logic [nmcm_pkg::LVL_W-1:0]     cur_lvl;
  logic [nmcm_pkg::IDX_W-1:0]     cur_idx;
  logic [nmcm_pkg::IDX_W-1:0]     parent;
  logic [nmcm_pkg::POS_W-1:0]     pos;
  logic                           first;
  logic [nmcm_pkg::NL_W-1:0]      bl;
  logic [nmcm_pkg::CNT_W-1:0]     bi;
  logic                           be;
  logic                           hit;

  logic [nmcm_pkg::COORD_W-1:0]   origin;
  logic [nmcm_pkg::COORD_W-1:0]   extent;
  logic [nmcm_pkg::RATIO_W-1:0]   ratio_raw;
  logic [nmcm_pkg::RATIO_W-1:0]   ratio;
  logic [nmcm_pkg::NL_W-1:0]      nl_eff;
  logic [nmcm_pkg::CNT_W-1:0]     cnt_raw;
  logic [nmcm_pkg::CNT_W-1:0]     cnt_eff;
  logic                           div_done;
  logic [nmcm_pkg::POS_W-1:0]     quotient;

  assign origin    = q_axis ? rd_entry.origin_y : rd_entry.origin_x;
  assign extent    = q_axis ? rd_entry.height : rd_entry.width;
  assign ratio_raw = ratio_store[cur_lvl];
  assign ratio     = (ratio_raw == '0) ? nmcm_pkg::RATIO_W'(1) : ratio_raw;
  assign nl_eff    = (num_levels > nmcm_pkg::NL_W'(nmcm_pkg::LEVELS))
                     ? nmcm_pkg::NL_W'(nmcm_pkg::LEVELS) : num_levels;
  assign cnt_raw   = count_store[bl[nmcm_pkg::LVL_W-1:0]];
  assign cnt_eff   = (cnt_raw > nmcm_pkg::CNT_W'(nmcm_pkg::GRIDS_PER_LEVEL))
                     ? nmcm_pkg::CNT_W'(nmcm_pkg::GRIDS_PER_LEVEL) : cnt_raw;

  nmcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (op == nmcm_pkg::OP_DIV_START),
    .dividend (pos),
    .divisor  (ratio),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    status.is_boundary = q_bnd;
    status.first       = first;
    status.lvl_zero    = (cur_lvl == '0);
    status.div_done    = div_done;
    status.level_ok    = (bl < nl_eff);
    status.index_ok    = (bi < cnt_eff);
    status.match       = (pos == nmcm_pkg::POS_W'(q_coord));
    status.out_free    = !m_axis_tvalid || m_axis_tready;
  end

  // table: write on a load transfer, registered read at the walk pointer
  always_ff @(posedge clk) begin
    if (op == nmcm_pkg::OP_ACCEPT && in_cmd == nmcm_pkg::CMD_LOAD_ENTRY) begin
      mem[{in_level, in_grid}] <= in_entry;
    end
    rd_entry <= mem[{cur_lvl, cur_idx}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_levels <= nmcm_pkg::NL_W'(1);
      for (int l = 0; l < nmcm_pkg::LEVELS; l++) begin
        ratio_store[l] <= nmcm_pkg::RATIO_W'(1);
        count_store[l] <= '0;
      end
    end else begin
      if (cfg_we) begin
        num_levels <= cfg_wdata;
      end
      if (op == nmcm_pkg::OP_ACCEPT && in_cmd == nmcm_pkg::CMD_LOAD_LEVEL) begin
        ratio_store[in_level] <= in_ratio;
        count_store[in_level] <= in_count;
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    unique case (op)
      nmcm_pkg::OP_ACCEPT: begin
        q_axis  <= in_axis;
        q_bnd   <= (in_cmd == nmcm_pkg::CMD_BOUNDARY);
        q_coord <= in_coord;
        cur_lvl <= in_level;
        cur_idx <= in_grid;
        first   <= 1'b1;
        bl      <= nmcm_pkg::NL_W'(1);
        bi      <= '0;
        be      <= 1'b0;
        hit     <= 1'b0;
      end
      nmcm_pkg::OP_MAP_INIT: begin
        pos    <= nmcm_pkg::POS_W'(origin) + nmcm_pkg::POS_W'(q_coord);
        parent <= rd_entry.parent;
        first  <= 1'b0;
      end
      nmcm_pkg::OP_EDGE_INIT: begin
        pos    <= nmcm_pkg::POS_W'(origin) + (be ? nmcm_pkg::POS_W'(extent) : '0);
        parent <= rd_entry.parent;
        first  <= 1'b0;
      end
      nmcm_pkg::OP_ADD: begin
        pos    <= nmcm_pkg::POS_W'(origin) + pos;
        parent <= rd_entry.parent;
      end
      nmcm_pkg::OP_DIV_TAKE: begin
        pos <= quotient;
        // climb to the parent unless already on level zero
        if (cur_lvl != '0) begin
          cur_lvl <= cur_lvl - 1'b1;
          cur_idx <= parent;
        end
      end
      nmcm_pkg::OP_NEXT_LEVEL: begin
        bl <= bl + 1'b1;
        bi <= '0;
      end
      nmcm_pkg::OP_EDGE_START: begin
        cur_lvl <= bl[nmcm_pkg::LVL_W-1:0];
        cur_idx <= bi[nmcm_pkg::IDX_W-1:0];
        first   <= 1'b1;
      end
      nmcm_pkg::OP_NEXT_EDGE: begin
        if (be) begin
          be <= 1'b0;
          bi <= bi + 1'b1;
        end else begin
          be <= 1'b1;
        end
      end
      nmcm_pkg::OP_HIT: hit <= 1'b1;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (op == nmcm_pkg::OP_EMIT) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == nmcm_pkg::OP_EMIT) begin
      m_axis_tuser <= q_bnd;
      m_axis_tdata <= {5'd0, q_bnd & hit, q_bnd ? '0 : pos};
    end
  end

endmodule

// ===== src/nmcm_ctrl.sv =====
// Controller state machine sequencing map and boundary walks.
// Issues datapath ops; depends on nmcm_pkg.
module nmcm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic [1:0]            s_axis_tuser,
  output logic                  s_axis_tready,
  input  nmcm_pkg::dp_status_t  status,
  output nmcm_pkg::dp_op_t      op
);

  nmcm_pkg::state_t state;
  nmcm_pkg::state_t state_next;
  nmcm_pkg::cmd_t   cmd;

  assign cmd = nmcm_pkg::cmd_t'(s_axis_tuser);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nmcm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    op            = nmcm_pkg::OP_NONE;
    s_axis_tready = 1'b0;
    unique case (state)
      nmcm_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          op = nmcm_pkg::OP_ACCEPT;
          if (cmd == nmcm_pkg::CMD_MAP) begin
            state_next = nmcm_pkg::ST_READ;
          end else if (cmd == nmcm_pkg::CMD_BOUNDARY) begin
            state_next = nmcm_pkg::ST_SCAN;
          end
        end
      end
      nmcm_pkg::ST_READ: state_next = nmcm_pkg::ST_USE;
      nmcm_pkg::ST_USE: begin
        if (status.first) begin
          op = status.is_boundary ? nmcm_pkg::OP_EDGE_INIT : nmcm_pkg::OP_MAP_INIT;
        end else begin
          op = nmcm_pkg::OP_ADD;
        end
        // a map walk ends once the sum on level zero is formed
        if (!status.is_boundary && status.lvl_zero) begin
          state_next = nmcm_pkg::ST_EMIT;
        end else begin
          state_next = nmcm_pkg::ST_DIV_GO;
        end
      end
      nmcm_pkg::ST_DIV_GO: begin
        op         = nmcm_pkg::OP_DIV_START;
        state_next = nmcm_pkg::ST_DIV_WAIT;
      end
      nmcm_pkg::ST_DIV_WAIT: begin
        if (status.div_done) begin
          op = nmcm_pkg::OP_DIV_TAKE;
          if (status.is_boundary && status.lvl_zero) begin
            state_next = nmcm_pkg::ST_CHECK;
          end else begin
            state_next = nmcm_pkg::ST_READ;
          end
        end
      end
      nmcm_pkg::ST_SCAN: begin
        if (!status.level_ok) begin
          state_next = nmcm_pkg::ST_EMIT;
        end else if (!status.index_ok) begin
          op = nmcm_pkg::OP_NEXT_LEVEL;
        end else begin
          op         = nmcm_pkg::OP_EDGE_START;
          state_next = nmcm_pkg::ST_READ;
        end
      end
      nmcm_pkg::ST_CHECK: begin
        if (status.match) begin
          op         = nmcm_pkg::OP_HIT;
          state_next = nmcm_pkg::ST_EMIT;
        end else begin
          op         = nmcm_pkg::OP_NEXT_EDGE;
          state_next = nmcm_pkg::ST_SCAN;
        end
      end
      nmcm_pkg::ST_EMIT: begin
        if (status.out_free) begin
          op         = nmcm_pkg::OP_EMIT;
          state_next = nmcm_pkg::ST_IDLE;
        end
      end
      default: state_next = nmcm_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== src/nested_mesh_coordinate_mapper_top.sv =====
// Top level of the nested mesh coordinate mapper.
// Joins nmcm_ctrl and nmcm_datapath; depends on nmcm_pkg.
//
// Loads are taken in the idle state, which keeps the input ready. A map query reads
// the entry of its grid, adds origin and coordinate, and divides by the level ratio
// while it climbs the parent chain until the sum on level zero is formed; a boundary
// query walks the submesh edges of levels 1..num_levels-1 up their parent chains
// until one matches. The pace is set by the single table read port and the
// bit-serial divider shared by all steps. One item is in work at a time; a result
// waits in the output register while the next item is taken.
module nested_mesh_coordinate_mapper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // axis, level, grid_index, coordinate, new_origin_x, new_origin_y,
  // new_width, new_height, new_parent, new_ratio, new_count
  input  logic [95:0] s_axis_tdata,
  // command
  input  logic [1:0]  s_axis_tuser,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_wdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // level0_position, on_boundary, zero fill
  output logic [23:0] m_axis_tdata,
  // result_kind
  output logic        m_axis_tuser
);

  nmcm_pkg::dp_status_t status;
  nmcm_pkg::dp_op_t     op;

  nmcm_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tready (s_axis_tready),
    .status        (status),
    .op            (op)
  );

  nmcm_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .op            (op),
    .status        (status),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_kind_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser ? (m_axis_tdata[17:0] == '0) : !m_axis_tdata[18]))
    else $error("result fields disagree with result kind");

  a_div_restart: assert property (@(posedge clk) disable iff (rst)
    (op == nmcm_pkg::OP_DIV_START) |=> !status.div_done)
    else $error("divider reports done right after start");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == nmcm_pkg::CMD_MAP || s_axis_tuser == nmcm_pkg::CMD_BOUNDARY))
    |=> !s_axis_tready)
    else $error("query accepted but input stays ready");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    (op == nmcm_pkg::OP_EMIT) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result written over a pending transfer");

endmodule
